// ----- rtl/pbpi_pkg.sv -----
// ----------------------------------------------------------------------------
// pbpi_pkg
// shared widths, reset values and status codes of the pulse baseline, peak
// and integral block
// ----------------------------------------------------------------------------
package pbpi_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int FRAC_W        = 8;
    localparam int MAX_EVENT_LEN = 1024;
    localparam int POS_W         = $clog2(MAX_EVENT_LEN);
    localparam int LEN_W         = POS_W + 1;
    localparam int COUNT_W       = 10;
    localparam int SUM_W         = SAMPLE_W + POS_W;
    localparam int QUO_W         = SUM_W + FRAC_W;
    localparam int STEP_W        = $clog2(QUO_W + 1);
    localparam int BASE_W        = 24;
    localparam int AMP_W         = 25;
    localparam int INTEG_W       = 35;

    localparam logic [COUNT_W-1:0] BASELINE_COUNT_RESET = COUNT_W'(16);

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_LENGTH = 2'd1,
        STATUS_COUNT  = 2'd2
    } status_t;

endpackage

// ----- rtl/pbpi_div.sv -----
// ----------------------------------------------------------------------------
// pbpi_div
// restoring divider, one quotient bit per cycle, truncation toward zero
// ----------------------------------------------------------------------------
module pbpi_div
    import pbpi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [QUO_W-1:0]          dividend,
    input  logic                      negate,
    input  logic [COUNT_W-1:0]        divisor,
    output logic                      done,
    output logic signed [QUO_W-1:0]   quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic [COUNT_W-1:0]   div_reg;

    logic [COUNT_W:0]     rem_shift;
    logic                 fits;
    logic [COUNT_W:0]     rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QUO_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_sub   = rem_shift - {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= negate;
                step_reg <= STEP_W'(QUO_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                quo_reg  <= {quo_reg[QUO_W-2:0], fits};
                rem_reg  <= fits ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("divider done held for two cycles");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && !done)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

// ----- rtl/pulse_baseline_peak_integral.sv -----
// ----------------------------------------------------------------------------
// pulse_baseline_peak_integral
// per-event baseline mean, peak amplitude and index, and baseline-corrected
// charge integral over a stream of converter samples
//
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     sample, last
// out       output     out_valid / out_stall   status, baseline, peak_height,
//                                              peak_offset, integral
// cfg       input      baseline_count_we       baseline_count_wdata
//
// a sample beat without last is absorbed without stalling the input
// a last beat runs the serial divider for the baseline, then a multiply step and
//   the output load; error events go straight to the output load
// in_stall is high while an event result is being computed or is waiting for
//   a free output register
// rst_n clears the event state and sets baseline_count to 16
// ----------------------------------------------------------------------------
module pulse_baseline_peak_integral
    import pbpi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic signed [BASE_W-1:0]    baseline,
    output logic signed [AMP_W-1:0]     peak_height,
    output logic [POS_W-1:0]            peak_offset,
    output logic signed [INTEG_W-1:0]   integral,
    input  logic                        baseline_count_we,
    input  logic [COUNT_W-1:0]          baseline_count_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_MUL,
        S_LOAD
    } state_t;

    state_t                      state_reg;
    logic [COUNT_W-1:0]          count_reg;
    logic [POS_W-1:0]            pos_reg;
    logic                        ovf_reg;
    logic signed [SUM_W-1:0]     head_reg;
    logic signed [SUM_W-1:0]     tail_reg;
    logic signed [SAMPLE_W-1:0]  max_reg;
    logic [POS_W-1:0]            max_pos_reg;
    logic [COUNT_W-1:0]          k_snap_reg;
    logic [LEN_W-1:0]            len_reg;
    status_t                     status_reg;
    logic signed [QUO_W-1:0]     base_reg;
    logic [INTEG_W-1:0]          prod_reg;
    logic [AMP_W-1:0]            amp_reg;

    logic                        out_valid_reg;
    status_t                     out_status_reg;
    logic [BASE_W-1:0]           out_base_reg;
    logic [AMP_W-1:0]            out_amp_reg;
    logic [POS_W-1:0]            out_index_reg;
    logic [INTEG_W-1:0]          out_integ_reg;

    logic                        in_accept;
    logic                        out_free;
    logic signed [SUM_W-1:0]     sample_ext;
    logic                        in_head;
    logic signed [SUM_W-1:0]     head_next;
    logic signed [SUM_W-1:0]     tail_next;
    logic signed [SAMPLE_W-1:0]  max_next;
    logic [POS_W-1:0]            max_pos_next;
    logic [POS_W-1:0]            pos_next;
    logic                        ovf_next;
    logic [LEN_W-1:0]            len_now;
    status_t                     status_now;

    logic                        div_start;
    logic                        div_done;
    logic [SUM_W-1:0]            head_mag;
    logic signed [QUO_W-1:0]     div_quo;
    logic [INTEG_W-1:0]          base_ext;
    logic [LEN_W-1:0]            tail_cnt;
    logic [INTEG_W-1:0]          tail_scaled;
    logic [AMP_W-1:0]            max_scaled;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // per-sample accumulate
    always_comb
    begin
        sample_ext   = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
        in_head      = pos_reg < count_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        max_next     = max_reg;
        max_pos_next = max_pos_reg;
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;
        if (!ovf_reg)
        begin
            if (in_head)
            begin
                head_next = head_reg + sample_ext;
            end
            else
            begin
                tail_next = tail_reg + sample_ext;
                if (pos_reg == count_reg || sample > max_reg)
                begin
                    max_next     = sample;
                    max_pos_next = pos_reg;
                end
            end
            if (!last)
            begin
                if (pos_reg == POS_W'(MAX_EVENT_LEN - 1))
                    ovf_next = 1'b1;
                else
                    pos_next = pos_reg + POS_W'(1);
            end
        end
        len_now = {1'b0, pos_reg} + LEN_W'(1);
        if (ovf_reg || len_now < LEN_W'(2))
            status_now = STATUS_LENGTH;
        else if (count_reg == '0 || {1'b0, count_reg} >= len_now)
            status_now = STATUS_COUNT;
        else
            status_now = STATUS_OK;
    end

    // end-of-event arithmetic
    always_comb
    begin
        div_start   = (state_reg == S_START);
        head_mag    = head_reg[SUM_W-1] ? SUM_W'(-head_reg) : SUM_W'(head_reg);
        base_ext    = {{(INTEG_W-QUO_W){base_reg[QUO_W-1]}}, base_reg};
        tail_cnt    = len_reg - {1'b0, k_snap_reg};
        tail_scaled = {{(INTEG_W-SUM_W-FRAC_W){tail_reg[SUM_W-1]}}, tail_reg,
                       {FRAC_W{1'b0}}};
        max_scaled  = {{(AMP_W-SAMPLE_W-FRAC_W){max_reg[SAMPLE_W-1]}}, max_reg,
                       {FRAC_W{1'b0}}};
    end

    pbpi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({head_mag, {FRAC_W{1'b0}}}),
        .negate   (head_reg[SUM_W-1]),
        .divisor  (k_snap_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= BASELINE_COUNT_RESET;
            pos_reg        <= '0;
            ovf_reg        <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            max_reg        <= '0;
            max_pos_reg    <= '0;
            k_snap_reg     <= '0;
            len_reg        <= '0;
            status_reg     <= STATUS_OK;
            base_reg       <= '0;
            prod_reg       <= '0;
            amp_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_base_reg   <= '0;
            out_amp_reg    <= '0;
            out_index_reg  <= '0;
            out_integ_reg  <= '0;
        end
        else
        begin
            if (baseline_count_we)
                count_reg <= baseline_count_wdata;

            if (state_reg == S_LOAD && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        head_reg    <= head_next;
                        tail_reg    <= tail_next;
                        max_reg     <= max_next;
                        max_pos_reg <= max_pos_next;
                        pos_reg     <= pos_next;
                        ovf_reg     <= ovf_next;
                        if (last)
                        begin
                            k_snap_reg <= count_reg;
                            len_reg    <= len_now;
                            status_reg <= status_now;
                            state_reg  <= (status_now == STATUS_OK) ? S_START : S_LOAD;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        base_reg  <= div_quo;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= base_ext * INTEG_W'(tail_cnt);
                    amp_reg   <= max_scaled - base_reg[AMP_W-1:0];
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= status_reg;
                        if (status_reg == STATUS_OK)
                        begin
                            out_base_reg  <= base_reg[BASE_W-1:0];
                            out_amp_reg   <= amp_reg;
                            out_index_reg <= max_pos_reg;
                            out_integ_reg <= tail_scaled - prod_reg;
                        end
                        else
                        begin
                            out_base_reg  <= '0;
                            out_amp_reg   <= '0;
                            out_index_reg <= '0;
                            out_integ_reg <= '0;
                        end
                        pos_reg     <= '0;
                        ovf_reg     <= 1'b0;
                        head_reg    <= '0;
                        tail_reg    <= '0;
                        max_reg     <= '0;
                        max_pos_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign baseline    = $signed(out_base_reg);
    assign peak_height = $signed(out_amp_reg);
    assign peak_offset = out_index_reg;
    assign integral    = $signed(out_integ_reg);

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && last |=> in_stall)
        else $error("input not stalled after last beat");

    a_ovf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> pos_reg == POS_W'(MAX_EVENT_LEN - 1))
        else $error("length overflow with position below limit");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> baseline == '0 && peak_height == '0
            && peak_offset == '0 && integral == '0)
        else $error("error result with nonzero fields");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> k_snap_reg != '0 && status_reg == STATUS_OK)
        else $error("divide started on a rejected event");

endmodule
